@@ rtl/core/lwed_pkg.sv @@
// Shared types, codes and field widths of the light window event detector.
`timescale 1ns / 1ps

package lwed_pkg;

  // Fixed field widths of the item and result ports.
  localparam int SAMPLE_W    = 20;
  localparam int MARGIN_W    = 16;
  localparam int OPCODE_W    = 2;
  localparam int FREQ_W      = 8;
  localparam int SLOT_PORT_W = 4;
  localparam int STATUS_W    = 2;
  localparam int BITS_W      = 16;

  // Noise margin after reset.
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd1000;

  // Item opcodes; the fourth code is ignored.
  localparam logic [OPCODE_W-1:0] OP_SIGNAL = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_CREATE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_EVENT = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SETUP,
    ST_SCAN,
    ST_REPORT
  } lwed_state_t;

  // Sample ring port controls.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ring_ctrl_t;

  // Compare unit controls.
  typedef struct packed {
    logic setup;
    logic accumulate;
  } qual_ctrl_t;

endpackage

@@ rtl/core/lwed_ring.sv @@
// Sample ring memory with write pointer, fill count and registered read port.
`timescale 1ns / 1ps

module lwed_ring
  import lwed_pkg::*;
#(
  parameter int WINDOW_SIZE = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ring_ctrl_t            ring_ctl,
  input  logic [SAMPLE_W-1:0]   wr_data,
  input  logic [(WINDOW_SIZE > 1 ? $clog2(WINDOW_SIZE) : 1)-1:0] rd_addr,
  output logic [SAMPLE_W-1:0]   rd_sample,
  output logic                  rd_last
);

  localparam int AW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CW = $clog2(WINDOW_SIZE + 1);

  logic [SAMPLE_W-1:0] mem [WINDOW_SIZE];
  logic [AW-1:0]       wp;
  logic [CW-1:0]       fill;
  logic [SAMPLE_W-1:0] rd_data;
  logic                rd_filled;

  // Write pointer and fill count; entries at or above the fill count still read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
    end else if (ring_ctl.wr_en) begin
      wp <= (wp == AW'(WINDOW_SIZE - 1)) ? '0 : AW'(wp + AW'(1));
      if (fill != CW'(WINDOW_SIZE)) begin
        fill <= CW'(fill + CW'(1));
      end
    end
  end

  // Memory write port.
  always_ff @(posedge clk) begin
    if (ring_ctl.wr_en) begin
      mem[wp] <= wr_data;
    end
  end

  // Registered read port, with the fill test and last-entry mark taken alongside.
  always_ff @(posedge clk) begin
    if (ring_ctl.rd_en) begin
      rd_data   <= mem[rd_addr];
      rd_filled <= CW'(rd_addr) < fill;
      rd_last   <= rd_addr == AW'(WINDOW_SIZE - 1);
    end
  end

  assign rd_sample = rd_filled ? rd_data : '0;

endmodule

@@ rtl/core/lwed_qual.sv @@
// Shared compare unit: threshold, per-sample compare and qualifying-sample count.
`timescale 1ns / 1ps

module lwed_qual
  import lwed_pkg::*;
#(
  parameter int WINDOW_SIZE = 32
) (
  input  logic                                   clk,
  input  qual_ctrl_t                             qual_ctl,
  input  logic [MARGIN_W-1:0]                    noise_margin,
  input  logic [SAMPLE_W-1:0]                    level,
  input  logic [$clog2(WINDOW_SIZE + 1)-1:0]     needed,
  input  logic [SAMPLE_W-1:0]                    sample,
  output logic                                   holds
);

  localparam int CW = $clog2(WINDOW_SIZE + 1);

  logic [SAMPLE_W-1:0] threshold;
  logic [CW-1:0]       needed_r;
  logic [CW-1:0]       hits;
  logic [SAMPLE_W-1:0] margin_ext;
  logic                qualifies;
  logic [CW-1:0]       hits_total;

  assign margin_ext = SAMPLE_W'(noise_margin);

  // Per-slot setup: a margin at or above the level lets every sample through.
  always_ff @(posedge clk) begin
    if (qual_ctl.setup) begin
      threshold <= (level > margin_ext) ? SAMPLE_W'(level - margin_ext) : '0;
      needed_r  <= needed;
      hits      <= '0;
    end else if (qual_ctl.accumulate) begin
      hits <= hits_total;
    end
  end

  // One compare per cycle; the count never passes the window size.
  assign qualifies  = sample >= threshold;
  assign hits_total = CW'(hits + CW'(qualifies));
  assign holds      = hits_total >= needed_r;

endmodule

@@ rtl/core/lwed_ctrl.sv @@
// Sequencer, event slot table, condition bits and result registers.
`timescale 1ns / 1ps

module lwed_ctrl
  import lwed_pkg::*;
#(
  parameter int WINDOW_SIZE = 32,
  parameter int EVENT_SLOTS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [OPCODE_W-1:0]                    opcode,
  input  logic [SAMPLE_W-1:0]                    intensity_value,
  input  logic [FREQ_W-1:0]                      frequency_request,
  input  logic [SLOT_PORT_W-1:0]                 event_slot,
  output logic                                   busy,
  output logic                                   result_valid,
  output logic [STATUS_W-1:0]                    status,
  output logic [SLOT_PORT_W-1:0]                 slot_assigned,
  output logic [BITS_W-1:0]                      condition_bits,
  output logic                                   condition_flag,
  output ring_ctrl_t                             ring_ctl,
  output logic [SAMPLE_W-1:0]                    wr_data,
  output logic [(WINDOW_SIZE > 1 ? $clog2(WINDOW_SIZE) : 1)-1:0] rd_addr,
  input  logic                                   rd_last,
  output qual_ctrl_t                             qual_ctl,
  output logic [SAMPLE_W-1:0]                    level,
  output logic [$clog2(WINDOW_SIZE + 1)-1:0]     needed,
  input  logic                                   holds
);

  localparam int AW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CW = $clog2(WINDOW_SIZE + 1);
  localparam int SW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int NW = $clog2(EVENT_SLOTS + 1);

  lwed_state_t state, state_next;

  // Latched item.
  logic [OPCODE_W-1:0]    op_r;
  logic [SAMPLE_W-1:0]    value_r;
  logic [CW-1:0]          need_r;
  logic [SLOT_PORT_W-1:0] query_slot_r;

  // Slot table and sequencer counters.
  logic [SAMPLE_W-1:0]    level_mem [EVENT_SLOTS];
  logic [CW-1:0]          need_mem  [EVENT_SLOTS];
  logic [EVENT_SLOTS-1:0] valid_bits;
  logic [EVENT_SLOTS-1:0] cond_bits;
  logic [NW-1:0]          next_slot;
  logic [SW-1:0]          slot_idx;
  logic [AW-1:0]          scan_addr;

  // Sequencer strobes.
  logic load;
  logic slot_set;
  logic slot_cond;
  logic slot_adv;
  logic scan_start;
  logic scan_step;
  logic create_ok;
  logic report;

  logic                   table_full;
  logic                   last_slot;
  logic                   query_ok;
  logic [SW-1:0]          ns_idx;
  logic [SW-1:0]          q_idx;
  logic [BITS_W-1:0]      gathered;
  logic [STATUS_W-1:0]    res_status;
  logic [SLOT_PORT_W-1:0] res_assigned;
  logic                   res_flag;
  logic [FREQ_W-1:0]      freq_clamped;

  assign busy    = state != ST_IDLE;
  assign wr_data = value_r;
  assign level   = level_mem[slot_idx];
  assign needed  = need_mem[slot_idx];

  assign table_full = next_slot >= NW'(EVENT_SLOTS);
  assign ns_idx     = next_slot[SW-1:0];
  assign q_idx      = query_slot_r[SW-1:0];
  assign last_slot  = NW'(NW'(slot_idx) + NW'(1)) == next_slot;
  assign query_ok   = ({1'b0, query_slot_r} < (SLOT_PORT_W + 1)'(EVENT_SLOTS))
                      && valid_bits[q_idx];
  assign freq_clamped = (frequency_request > FREQ_W'(WINDOW_SIZE))
                        ? FREQ_W'(WINDOW_SIZE) : frequency_request;

  // Condition bits of all slots, invalid slots reading zero.
  always_comb begin
    gathered = '0;
    for (int s = 0; s < EVENT_SLOTS; s++) begin
      gathered[s] = valid_bits[s] & cond_bits[s];
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and sequencer outputs.
  always_comb begin
    state_next   = state;
    ring_ctl     = '0;
    qual_ctl     = '0;
    rd_addr      = scan_addr;
    load         = 1'b0;
    slot_set     = 1'b0;
    slot_cond    = 1'b0;
    slot_adv     = 1'b0;
    scan_start   = 1'b0;
    scan_step    = 1'b0;
    create_ok    = 1'b0;
    report       = 1'b0;
    res_status   = STATUS_OK;
    res_assigned = '0;
    res_flag     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          load       = 1'b1;
          state_next = (opcode == OP_SIGNAL) ? ST_WRITE : ST_REPORT;
        end
      end
      ST_WRITE: begin
        ring_ctl.wr_en = 1'b1;
        state_next     = (next_slot == '0) ? ST_REPORT : ST_SETUP;
      end
      ST_SETUP: begin
        if (needed == '0) begin
          // A zero count always holds; no scan is needed.
          slot_set   = 1'b1;
          slot_cond  = 1'b1;
          slot_adv   = 1'b1;
          state_next = last_slot ? ST_REPORT : ST_SETUP;
        end else begin
          qual_ctl.setup = 1'b1;
          ring_ctl.rd_en = 1'b1;
          rd_addr        = '0;
          scan_start     = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_last) begin
          slot_set   = 1'b1;
          slot_cond  = holds;
          slot_adv   = 1'b1;
          state_next = last_slot ? ST_REPORT : ST_SETUP;
        end else begin
          qual_ctl.accumulate = 1'b1;
          ring_ctl.rd_en      = 1'b1;
          scan_step           = 1'b1;
        end
      end
      ST_REPORT: begin
        report     = 1'b1;
        state_next = ST_IDLE;
        case (op_r)
          OP_CREATE: begin
            if (table_full) begin
              res_status = STATUS_FULL;
            end else begin
              create_ok    = 1'b1;
              res_assigned = SLOT_PORT_W'(next_slot);
            end
          end
          OP_QUERY: begin
            if (query_ok) begin
              res_flag = cond_bits[q_idx];
            end else begin
              res_status = STATUS_NO_EVENT;
            end
          end
          default: begin
            res_status = STATUS_OK;
          end
        endcase
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Slot valid and condition bits, fill count of the slot table, result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits   <= '0;
      cond_bits    <= '0;
      next_slot    <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= report;
      if (slot_set) begin
        cond_bits[slot_idx] <= slot_cond;
      end
      if (create_ok) begin
        valid_bits[ns_idx] <= 1'b1;
        cond_bits[ns_idx]  <= 1'b0;
        next_slot          <= NW'(next_slot + NW'(1));
      end
    end
  end

  // Item latch, slot table contents, counters and result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      op_r         <= opcode;
      value_r      <= intensity_value;
      need_r       <= CW'(freq_clamped);
      query_slot_r <= event_slot;
      slot_idx     <= '0;
    end else if (slot_adv) begin
      slot_idx <= SW'(slot_idx + SW'(1));
    end
    if (scan_start) begin
      scan_addr <= (WINDOW_SIZE > 1) ? AW'(1) : '0;
    end else if (scan_step) begin
      scan_addr <= AW'(scan_addr + AW'(1));
    end
    if (create_ok) begin
      level_mem[ns_idx] <= value_r;
      need_mem[ns_idx]  <= need_r;
    end
    if (report) begin
      status         <= res_status;
      slot_assigned  <= res_assigned;
      condition_bits <= gathered;
      condition_flag <= res_flag;
    end
  end

endmodule

@@ rtl/core/light_window_event_detector.sv @@
// Top level of the light window event detector.
//
//   channel   direction  handshake                    payload
//   item      in         start, accepted when !busy   opcode, intensity_value,
//                                                     frequency_request, event_slot
//   result    out        result_valid, one cycle      status, slot_assigned,
//                                                     condition_bits, condition_flag
//   config    in         cfg_valid / cfg_ready        cfg_data (noise margin)
//
// Create, query and unused items go from the transfer straight to the report state;
// the result strobe is registered from it. A signal item writes its sample, then the
// single comparator walks the sample ring one entry a cycle for each created slot, or
// settles a zero-count slot at once. busy is low again in the cycle of the strobe.
// Reset is synchronous and clears the ring fill count, the slot table and the margin
// (to 1000). The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module light_window_event_detector
  import lwed_pkg::*;
#(
  parameter int WINDOW_SIZE = 32,
  parameter int EVENT_SLOTS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [OPCODE_W-1:0]    opcode,
  input  logic [SAMPLE_W-1:0]    intensity_value,
  input  logic [FREQ_W-1:0]      frequency_request,
  input  logic [SLOT_PORT_W-1:0] event_slot,
  output logic                   result_valid,
  output logic [STATUS_W-1:0]    status,
  output logic [SLOT_PORT_W-1:0] slot_assigned,
  output logic [BITS_W-1:0]      condition_bits,
  output logic                   condition_flag,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [MARGIN_W-1:0]    cfg_data
);

  localparam int AW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CW = $clog2(WINDOW_SIZE + 1);

  logic [MARGIN_W-1:0] noise_margin;
  ring_ctrl_t          ring_ctl;
  qual_ctrl_t          qual_ctl;
  logic [SAMPLE_W-1:0] wr_data;
  logic [AW-1:0]       rd_addr;
  logic [SAMPLE_W-1:0] rd_sample;
  logic                rd_last;
  logic [SAMPLE_W-1:0] level;
  logic [CW-1:0]       needed;
  logic                holds;

  // Noise margin register; the write channel is always open.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_margin <= MARGIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      noise_margin <= cfg_data;
    end
  end

  lwed_ctrl #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .EVENT_SLOTS (EVENT_SLOTS)
  ) u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .opcode            (opcode),
    .intensity_value   (intensity_value),
    .frequency_request (frequency_request),
    .event_slot        (event_slot),
    .busy              (busy),
    .result_valid      (result_valid),
    .status            (status),
    .slot_assigned     (slot_assigned),
    .condition_bits    (condition_bits),
    .condition_flag    (condition_flag),
    .ring_ctl          (ring_ctl),
    .wr_data           (wr_data),
    .rd_addr           (rd_addr),
    .rd_last           (rd_last),
    .qual_ctl          (qual_ctl),
    .level             (level),
    .needed            (needed),
    .holds             (holds)
  );

  lwed_ring #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_ring (
    .clk       (clk),
    .rst       (rst),
    .ring_ctl  (ring_ctl),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_sample (rd_sample),
    .rd_last   (rd_last)
  );

  lwed_qual #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_qual (
    .clk          (clk),
    .qual_ctl     (qual_ctl),
    .noise_margin (noise_margin),
    .level        (level),
    .needed       (needed),
    .sample       (rd_sample),
    .holds        (holds)
  );

endmodule

@@ rtl/core/lwed_checker.sv @@
// Port-level checks of the light window event detector and their binding.
`timescale 1ns / 1ps

module lwed_checker
  import lwed_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   result_valid,
  input logic [STATUS_W-1:0]    status,
  input logic [SLOT_PORT_W-1:0] slot_assigned,
  input logic                   condition_flag
);

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after an item transfer");

  // A result strobe lasts one cycle and is never back to back.
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for more than one cycle");

  // A result is only shown once the item has finished.
  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result shown while still busy");

  // A failed create or query reports no slot and no condition.
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status == STATUS_FULL || status == STATUS_NO_EVENT))
      |-> (slot_assigned == '0 && !condition_flag))
    else $error("failed item reports a slot or a condition");

endmodule

bind light_window_event_detector lwed_checker u_lwed_checker (.*);
